@@ hdl/tea_pkg.sv @@
// Shared types, constants and the TEA mixing function for the block encryptor.
// No dependencies; imported by every module under hdl.
package tea_pkg;

  localparam int WORD_W      = 32;
  localparam int ROUNDS_W    = 11;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0]   DELTA      = 32'h9e37_79b9;
  localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = 11'd1024;
  localparam logic [ROUNDS_W-1:0] ROUNDS_MIN = 11'd1;

  localparam logic [WORD_W-1:0] KEY0_RST = 32'h0123_4567;
  localparam logic [WORD_W-1:0] KEY1_RST = 32'h89ab_cdef;
  localparam logic [WORD_W-1:0] KEY2_RST = 32'h1357_9248;
  localparam logic [WORD_W-1:0] KEY3_RST = 32'h248a_0135;

  localparam int SHL_AMT = 4;
  localparam int SHR_AMT = 5;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4
  } tea_reg_e;

  typedef struct packed {
    logic [WORD_W-1:0] plain_first;
    logic [WORD_W-1:0] plain_second;
  } tea_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] cipher_first;
    logic [WORD_W-1:0] cipher_second;
  } tea_out_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  // one queued block with its round count already clamped
  typedef struct packed {
    tea_in_t             blk;
    logic [ROUNDS_W-1:0] rounds;
  } tea_job_t;

  function automatic logic [WORD_W-1:0] mix_term(
    input logic [WORD_W-1:0] w,
    input logic [WORD_W-1:0] total,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    return ((w << SHL_AMT) + ka) ^ (w + total) ^ ((w >> SHR_AMT) + kb);
  endfunction

endpackage

@@ hdl/tea_front.sv @@
// Front end: takes plaintext beats, clamps the round count and queues jobs.
// Depends on tea_pkg.
module tea_front
  import tea_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                plain_valid,
  output logic                plain_ready,
  input  tea_in_t             plain,
  input  logic [ROUNDS_W-1:0] round_count,
  output logic                job_valid,
  input  logic                job_ready,
  output tea_job_t            job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tea_job_t            mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic [ROUNDS_W-1:0] rounds_clamped;
  logic                push;
  logic                pop;

  always_comb begin
    if (round_count == '0) begin
      rounds_clamped = ROUNDS_MIN;
    end else if (round_count > ROUNDS_MAX) begin
      rounds_clamped = ROUNDS_MAX;
    end else begin
      rounds_clamped = round_count;
    end
  end

  assign plain_ready = (count != CNT_FULL);
  assign job_valid   = (count != '0);
  assign job         = mem[rd_ptr];
  assign push        = plain_valid && plain_ready;
  assign pop         = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{blk: plain, rounds: rounds_clamped};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/tea_core.sv @@
// Back end: iterative TEA round engine, one full round per clock, plus the
// output register. Depends on tea_pkg.
module tea_core
  import tea_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tea_key_t key,
  input  logic     job_valid,
  output logic     job_ready,
  input  tea_job_t job,
  output logic     cipher_valid,
  input  logic     cipher_ready,
  output tea_out_t cipher
);

  logic                busy;
  logic [ROUNDS_W-1:0] cnt;
  logic [WORD_W-1:0]   left;
  logic [WORD_W-1:0]   right;
  logic [WORD_W-1:0]   total;
  logic [WORD_W-1:0]   total_next;
  logic [WORD_W-1:0]   left_next;
  logic [WORD_W-1:0]   right_next;
  logic                stepping;
  logic                finish;

  assign total_next = total + DELTA;
  assign left_next  = left + mix_term(right, total_next, key.k0, key.k1);
  assign right_next = right + mix_term(left_next, total_next, key.k2, key.k3);

  assign stepping  = busy && (cnt != '0);
  // rounds done and the output register free, or freeing this cycle
  assign finish    = busy && (cnt == '0) && (!cipher_valid || cipher_ready);
  assign job_ready = !busy || finish;

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      left  <= job.blk.plain_first;
      right <= job.blk.plain_second;
      total <= '0;
    end else if (stepping) begin
      left  <= left_next;
      right <= right_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      cipher <= '{cipher_first: left, cipher_second: right};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      cnt          <= '0;
      cipher_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        busy <= 1'b1;
        cnt  <= job.rounds;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (stepping) begin
        cnt <= cnt - 1'b1;
      end
      if (finish) begin
        cipher_valid <= 1'b1;
      end else if (cipher_ready) begin
        cipher_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/tea_block_encrypt.sv @@
// TEA block encryptor. An accepted block is queued, runs N rounds in the
// round engine and is registered at the output, N being the clamped round
// count (1..1024, 1024 after reset). The single round engine does one full
// round a clock; a small job queue keeps the input side taking beats meanwhile.
// Reset restores the default key and 1024 rounds and empties queue and engine.
// Depends on tea_pkg, tea_front and tea_core.
module tea_block_encrypt
  import tea_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              plain_valid,
  output logic              plain_ready,
  input  tea_in_t           plain,
  output logic              cipher_valid,
  input  logic              cipher_ready,
  output tea_out_t          cipher,
  input  logic              cfg_wen,
  input  logic [2:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  tea_key_t            key;
  logic [ROUNDS_W-1:0] round_count;
  logic                job_valid;
  logic                job_ready;
  tea_job_t            job;

  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= '{k0: KEY0_RST, k1: KEY1_RST, k2: KEY2_RST, k3: KEY3_RST};
      round_count <= ROUNDS_MAX;
    end else if (cfg_wen) begin
      unique case (tea_reg_e'(cfg_index))
        REG_KEY0:   key.k0      <= cfg_data;
        REG_KEY1:   key.k1      <= cfg_data;
        REG_KEY2:   key.k2      <= cfg_data;
        REG_KEY3:   key.k3      <= cfg_data;
        REG_ROUNDS: round_count <= cfg_data[ROUNDS_W-1:0];
        default:    ;
      endcase
    end
  end

  tea_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .plain_valid (plain_valid),
    .plain_ready (plain_ready),
    .plain       (plain),
    .round_count (round_count),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job)
  );

  tea_core u_core (
    .clk          (clk),
    .rst          (rst),
    .key          (key),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job),
    .cipher_valid (cipher_valid),
    .cipher_ready (cipher_ready),
    .cipher       (cipher)
  );

endmodule

@@ hdl/tea_chk.sv @@
// Port-level checks for tea_block_encrypt, bound to the top level.
// Depends on tea_pkg.
module tea_chk
  import tea_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     plain_valid,
  input logic     plain_ready,
  input logic     cipher_valid,
  input logic     cipher_ready,
  input tea_out_t cipher
);

  logic [7:0] pending;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = plain_valid && plain_ready;
  assign out_beat = cipher_valid && cipher_ready;

  // blocks taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(in_beat) - 8'(out_beat);
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> !cipher_valid && plain_ready)
    else $error("block not empty after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    cipher_valid |-> pending != '0)
    else $error("result without an outstanding block");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_beat && pending == '0 |=> !cipher_valid)
    else $error("result appeared the cycle after an idle accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    cipher_valid && !cipher_ready |=> cipher_valid && $stable(cipher))
    else $error("stalled result beat changed");

endmodule

bind tea_block_encrypt tea_chk u_tea_chk (
  .clk          (clk),
  .rst          (rst),
  .plain_valid  (plain_valid),
  .plain_ready  (plain_ready),
  .cipher_valid (cipher_valid),
  .cipher_ready (cipher_ready),
  .cipher       (cipher)
);
